FILE: hw/rtl/htwd_pkg.sv
package htwd_pkg;

  localparam int NODE_SLOTS = 2047;
  localparam int ADDR_W     = 11;
  localparam int WALK_W     = 12;
  localparam int OP_W       = 2;
  localparam int SYM_W      = 8;
  localparam int ENTRY_W    = SYM_W + 1;
  localparam int BYTE_W     = 8;
  localparam int REMAIN_W   = 4;

  localparam logic [OP_W-1:0] OP_NODE   = 2'd0;
  localparam logic [OP_W-1:0] OP_HEADER = 2'd1;
  localparam logic [OP_W-1:0] OP_CODE   = 2'd2;

  localparam logic [ADDR_W-1:0] TABLE_SIZE_RESET = 11'd2047;
  localparam logic [BYTE_W-1:0] LAST_BIT_POS     = 8'd7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_FLUSH
  } walk_state_t;

  typedef struct packed {
    logic             push;
    logic [SYM_W-1:0] symbol;
    logic             run_last;
    logic             out_of_range;
  } res_beat_t;

  typedef struct packed {
    logic clearing;
    logic pending;
  } walk_stat_t;

endpackage

FILE: hw/rtl/htwd_in_if.sv
interface htwd_in_if;
  import htwd_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] node_index;
  logic              node_is_leaf;
  logic [SYM_W-1:0]  node_symbol;
  logic [BYTE_W-1:0] code_byte;
  logic              final_byte;

  modport source (
    output valid, operation, node_index, node_is_leaf, node_symbol, code_byte, final_byte,
    input  ready
  );

  modport sink (
    input  valid, operation, node_index, node_is_leaf, node_symbol, code_byte, final_byte,
    output ready
  );
endinterface

FILE: hw/rtl/htwd_out_if.sv
interface htwd_out_if;
  import htwd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             run_last;
  logic             out_of_range;

  modport source (
    output valid, symbol, run_last, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, symbol, run_last, out_of_range,
    output ready
  );
endinterface

FILE: hw/rtl/htwd_cfg_if.sv
interface htwd_cfg_if;
  import htwd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] table_size;

  modport source (
    output valid, table_size,
    input  ready
  );

  modport sink (
    input  valid, table_size,
    output ready
  );
endinterface

FILE: hw/rtl/htwd_node_mem.sv
module htwd_node_mem (
  input  logic                         clk,
  input  logic                         we,
  input  logic [htwd_pkg::ADDR_W-1:0]  waddr,
  input  logic [htwd_pkg::ENTRY_W-1:0] wdata,
  input  logic [htwd_pkg::ADDR_W-1:0]  raddr,
  output logic [htwd_pkg::ENTRY_W-1:0] rdata
);
  import htwd_pkg::*;

  logic [ENTRY_W-1:0] mem [NODE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/htwd_walker.sv
module htwd_walker (
  input  logic                         clk,
  input  logic                         rst,
  htwd_in_if.sink                      code,
  htwd_cfg_if.sink                     cfg,
  output logic                         mem_we,
  output logic [htwd_pkg::ADDR_W-1:0]  mem_waddr,
  output logic [htwd_pkg::ENTRY_W-1:0] mem_wdata,
  output logic [htwd_pkg::ADDR_W-1:0]  mem_raddr,
  input  logic [htwd_pkg::ENTRY_W-1:0] mem_rdata,
  output htwd_pkg::res_beat_t          beat,
  input  logic                         out_free,
  output htwd_pkg::walk_stat_t         status
);
  import htwd_pkg::*;

  walk_state_t         state, state_next;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic [WALK_W-1:0]   walk_index, walk_index_next;
  logic [BYTE_W-1:0]   final_bit_count, final_bit_count_next;
  logic [BYTE_W-1:0]   bits, bits_next;
  logic [REMAIN_W-1:0] remain, remain_next;
  logic                pend_valid, pend_valid_next;
  logic [SYM_W-1:0]    pend_symbol, pend_symbol_next;
  logic                pend_oor, pend_oor_next;
  logic [ADDR_W-1:0]   table_size;

  logic                accept;
  logic [REMAIN_W-1:0] nbits;
  logic                oor;
  logic                leaf;
  logic                hit;
  logic [ADDR_W-1:0]   base;
  logic [WALK_W-1:0]   walk_child;

  assign code.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign accept     = code.valid && code.ready;

  assign status.clearing = (state == ST_CLEAR);
  assign status.pending  = pend_valid;

  always_comb begin
    if (code.final_byte) begin
      nbits = (final_bit_count <= LAST_BIT_POS) ?
              final_bit_count[REMAIN_W-1:0] + REMAIN_W'(1) : '0;
    end else begin
      nbits = REMAIN_W'(BYTE_W);
    end
  end

  // The node read for walk_index is in mem_rdata whenever the walk is active.
  assign oor        = walk_index >= {1'b0, table_size};
  assign leaf       = mem_rdata[ENTRY_W-1];
  assign hit        = oor || leaf;
  assign base       = leaf ? '0 : walk_index[ADDR_W-1:0];
  assign walk_child = {base, 1'b0} + WALK_W'(1) + WALK_W'(bits[BYTE_W-1]);

  always_comb begin
    state_next           = state;
    clr_addr_next        = clr_addr;
    walk_index_next      = walk_index;
    final_bit_count_next = final_bit_count;
    bits_next            = bits;
    remain_next          = remain;
    pend_valid_next      = pend_valid;
    pend_symbol_next     = pend_symbol;
    pend_oor_next        = pend_oor;
    mem_we               = 1'b0;
    mem_waddr            = clr_addr;
    mem_wdata            = '0;
    mem_raddr            = walk_index[ADDR_W-1:0];
    beat                 = '0;

    unique case (state)
      ST_CLEAR: begin
        mem_we        = 1'b1;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(NODE_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (code.operation)
            OP_NODE: begin
              if (code.node_index < ADDR_W'(NODE_SLOTS)) begin
                mem_we    = 1'b1;
                mem_waddr = code.node_index;
                mem_wdata = {code.node_is_leaf, code.node_symbol};
              end
            end
            OP_HEADER: begin
              final_bit_count_next = code.code_byte;
              walk_index_next      = '0;
            end
            OP_CODE: begin
              if (nbits != '0) begin
                bits_next   = code.code_byte;
                remain_next = nbits;
                state_next  = ST_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        // A new result displaces the held one; wait if the output stage is full.
        if (!(hit && pend_valid && !out_free)) begin
          if (hit) begin
            beat.push         = pend_valid;
            beat.symbol       = pend_symbol;
            beat.run_last     = 1'b0;
            beat.out_of_range = pend_oor;
            pend_valid_next   = 1'b1;
            pend_symbol_next  = oor ? '0 : mem_rdata[SYM_W-1:0];
            pend_oor_next     = oor;
          end
          if (oor) begin
            state_next = ST_FLUSH;
          end else begin
            walk_index_next = walk_child;
            mem_raddr       = walk_child[ADDR_W-1:0];
            bits_next       = {bits[BYTE_W-2:0], 1'b0};
            remain_next     = remain - REMAIN_W'(1);
            if (remain == REMAIN_W'(1)) begin
              state_next = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          beat.push         = 1'b1;
          beat.symbol       = pend_symbol;
          beat.run_last     = 1'b1;
          beat.out_of_range = pend_oor;
          pend_valid_next   = 1'b0;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_addr        <= '0;
      walk_index      <= '0;
      final_bit_count <= '0;
      pend_valid      <= 1'b0;
      table_size      <= TABLE_SIZE_RESET;
    end else begin
      state           <= state_next;
      clr_addr        <= clr_addr_next;
      walk_index      <= walk_index_next;
      final_bit_count <= final_bit_count_next;
      pend_valid      <= pend_valid_next;
      if (cfg.valid && cfg.ready) begin
        table_size <= cfg.table_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    bits        <= bits_next;
    remain      <= remain_next;
    pend_symbol <= pend_symbol_next;
    pend_oor    <= pend_oor_next;
  end
endmodule

FILE: hw/rtl/htwd_out_reg.sv
module htwd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  htwd_pkg::res_beat_t beat,
  output logic                out_free,
  htwd_out_if.source          result
);
  import htwd_pkg::*;

  logic             valid;
  logic [SYM_W-1:0] symbol;
  logic             run_last;
  logic             out_of_range;

  assign out_free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (beat.push) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat.push) begin
      symbol       <= beat.symbol;
      run_last     <= beat.run_last;
      out_of_range <= beat.out_of_range;
    end
  end

  assign result.valid        = valid;
  assign result.symbol       = symbol;
  assign result.run_last     = run_last;
  assign result.out_of_range = out_of_range;
endmodule

FILE: hw/rtl/huffman_tree_walk_decoder_core.sv
// Huffman decoder that walks a heap-layout code tree held in a 2047-entry node memory, one
// examined bit per clock. After reset the node memory is cleared, during which no item is
// accepted (table_size writes are taken at all times). A code byte is accepted, the current
// node is fetched, one bit is examined per step (8 for a body byte, count+1 for a final
// byte, fewer if the walk goes out of range) and a closing step follows; the bound is the
// dependent node read per bit. Each symbol is held one step so that the last result of a
// byte carries run_last, and the walk waits while the output beat is stalled.
module huffman_tree_walk_decoder_core (
  input  logic       clk,
  input  logic       rst,
  htwd_in_if.sink    code,
  htwd_out_if.source result,
  htwd_cfg_if.sink   cfg
);
  import htwd_pkg::*;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  res_beat_t          beat;
  logic               out_free;
  walk_stat_t         status;

  htwd_node_mem u_node_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  htwd_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .code      (code),
    .cfg       (cfg),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .beat      (beat),
    .out_free  (out_free),
    .status    (status)
  );

  htwd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .beat     (beat),
    .out_free (out_free),
    .result   (result)
  );

`ifndef ASSERT_OFF
  a_clear_after_reset: assert property (@(posedge clk) $past(rst) |-> status.clearing)
    else $error("node memory clear did not start after reset");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !code.ready)
    else $error("input ready during node memory clear");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    status.pending |-> !code.ready)
    else $error("input ready while a result is still held");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    beat.push |-> out_free)
    else $error("result beat pushed into a full output stage");
`endif
endmodule
